// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, sampled on clk, quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rmth_pkg.sv =====
package rmth_pkg;

    localparam int HEAP_DEPTH  = 1024;
    localparam int MAX_SAMPLES = 2047;
    localparam int IDX_W       = $clog2(HEAP_DEPTH);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int SUM_W       = SIZE_W + 1;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int DATA_W      = 32;
    localparam int MED_W       = 33;
    localparam int CNT_W       = 11;
    localparam int CAP_HEAPS   = 2 * HEAP_DEPTH - 1;
    localparam int CAPACITY    = (MAX_SAMPLES < CAP_HEAPS) ? MAX_SAMPLES : CAP_HEAPS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_UP,
        ST_PUSH_CMP,
        ST_BALANCE,
        ST_POP_LAST,
        ST_POP_L,
        ST_POP_R,
        ST_POP_CMP,
        ST_POP_DONE,
        ST_FINISH
    } state_t;

    typedef enum logic {
        HEAP_LOWER = 1'b0,
        HEAP_UPPER = 1'b1
    } heap_sel_t;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } mem_req_t;

    typedef struct packed {
        logic signed [MED_W-1:0] median_doubled;
        logic [CNT_W-1:0]        sample_count;
        logic                    dropped;
    } result_t;

    typedef struct packed {
        logic              idle;
        logic [SIZE_W-1:0] lower_size;
        logic [SIZE_W-1:0] upper_size;
    } stat_t;

    // a belongs above b: max-heap for the lower half, min-heap for the upper half
    function automatic logic above(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b,
                                   input heap_sel_t sel);
        logic r;
        r = (sel == HEAP_LOWER) ? (a > b) : (a < b);
        return r;
    endfunction

endpackage

// ===== hw/rtl/rmth_if.sv =====
interface rmth_in_if import rmth_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rmth_out_if import rmth_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [MED_W-1:0] median_doubled;
    logic [CNT_W-1:0]        sample_count;
    logic                    dropped;

    modport source (output valid, output median_doubled, output sample_count,
                    output dropped, input ready);
    modport sink   (input valid, input median_doubled, input sample_count,
                    input dropped, output ready);
endinterface

// ===== hw/rtl/running_median_two_heaps_core.sv =====
// channel | dir | payload                                      | handshake
// src     | in  | sample (s32 q16.16)                          | valid / ready
// dst     | out | median_doubled (s33), sample_count, dropped  | valid / ready
//
// a dropped item goes straight to finish; an insert sifts up via push_up/push_cmp and
// a rebalance sifts down via pop_l/pop_r/pop_cmp, steps split over states by the single
// shared heap ram whose read data is registered, loops over log2 of the heap depth
// rst_n clears sizes and control; heap ram contents need no reset
// src is ready only while the sequencer is idle; a result waiting in the output
// register stalls the sequencer only at the last step of the following item
module running_median_two_heaps_core import rmth_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    rmth_in_if.sink    src,
    rmth_out_if.source dst
);

`include "assert_macros.svh"

    mem_req_t                 req;
    logic signed [DATA_W-1:0] rdata;
    logic                     res_valid;
    result_t                  res;
    stat_t                    stat;
    logic                     res_hold;

    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;

    logic [SUM_W-1:0]         held_total;
    logic                     sizes_close;

    // sequencer: insert, rebalance, sift loops
    rmth_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src),
        .res_hold  (res_hold),
        .rdata     (rdata),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .stat      (stat)
    );

    // both heaps share one ram
    rmth_ram u_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    // result register parts the sequencer from the consumer
    assign res_hold = out_valid_reg && !dst.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (dst.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign dst.valid          = out_valid_reg;
    assign dst.median_doubled = out_reg.median_doubled;
    assign dst.sample_count   = out_reg.sample_count;
    assign dst.dropped        = out_reg.dropped;

    assign held_total  = SUM_W'(stat.lower_size) + SUM_W'(stat.upper_size);
    assign sizes_close = (SUM_W'(stat.lower_size) <= SUM_W'(stat.upper_size) + SUM_W'(1))
                      && (SUM_W'(stat.upper_size) <= SUM_W'(stat.lower_size) + SUM_W'(1));

    // heap sizes never differ by more than one between items
    `CHECK_ALWAYS(a_balanced, !stat.idle || sizes_close, "heaps out of balance")
    // held count stays within capacity
    `CHECK_ALWAYS(a_capacity, held_total <= SUM_W'(CAPACITY), "count beyond capacity")
    // a finished result always lands in the output register
    `CHECK_NEXT(a_result_lands, res_valid, dst.valid, "result lost")

endmodule

// ===== hw/rtl/rmth_ram.sv =====
// both heaps in one array, heap select is the address msb
module rmth_ram import rmth_pkg::*; (
    input  logic                     clk,
    input  mem_req_t                 req,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [2*HEAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ===== hw/rtl/rmth_ctrl.sv =====
module rmth_ctrl import rmth_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    rmth_in_if.sink                  src,
    input  logic                     res_hold,
    input  logic signed [DATA_W-1:0] rdata,
    output mem_req_t                 req,
    output logic                     res_valid,
    output result_t                  res,
    output stat_t                    stat
);

    state_t                   state_reg, state_next;
    heap_sel_t                sel_reg, sel_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [SIZE_W-1:0]        n_reg, n_next;
    logic signed [DATA_W-1:0] last_reg, last_next;
    logic signed [DATA_W-1:0] bval_reg, bval_next;
    logic [SIZE_W-1:0]        best_reg, best_next;
    logic signed [DATA_W-1:0] top_val_reg, top_val_next;
    logic                     balanced_reg, balanced_next;
    logic                     drop_reg, drop_next;
    logic [SIZE_W-1:0]        lower_size_reg, lower_size_next;
    logic [SIZE_W-1:0]        upper_size_reg, upper_size_next;
    logic signed [DATA_W-1:0] lower_top_reg, lower_top_next;
    logic signed [DATA_W-1:0] upper_top_reg, upper_top_next;

    logic                     accept;
    logic [SUM_W-1:0]         total;
    logic                     full;
    logic                     lower_big;
    logic                     upper_big;
    heap_sel_t                pop_src;
    logic [SIZE_W-1:0]        src_size;
    logic [IDX_W-1:0]         parent;
    logic [SIZE_W-1:0]        l_idx;
    logic [SIZE_W-1:0]        r_idx;
    logic                     l_out;
    logic                     r_in;
    logic signed [DATA_W-1:0] cmp_a;
    logic signed [DATA_W-1:0] cmp_b;
    heap_sel_t                cmp_sel;
    logic                     hit;
    logic                     take_r;
    logic [SIZE_W-1:0]        best_fin;
    logic signed [DATA_W-1:0] bval_fin;
    logic                     sift_done;

    assign accept    = src.valid && src.ready;
    assign total     = SUM_W'(lower_size_reg) + SUM_W'(upper_size_reg);
    assign full      = total >= SUM_W'(CAPACITY);
    assign lower_big = SUM_W'(lower_size_reg) > SUM_W'(upper_size_reg) + SUM_W'(1);
    assign upper_big = SUM_W'(upper_size_reg) > SUM_W'(lower_size_reg) + SUM_W'(1);
    assign pop_src   = lower_big ? HEAP_LOWER : HEAP_UPPER;
    assign src_size  = lower_big ? lower_size_reg : upper_size_reg;
    assign parent    = (idx_reg - IDX_W'(1)) >> 1;
    assign l_idx     = {idx_reg, 1'b1};
    assign r_idx     = l_idx + SIZE_W'(1);
    assign l_out     = l_idx >= n_reg;
    assign r_in      = r_idx < n_reg;

    // the one comparator, operands picked by state
    always_comb
    begin
        cmp_a   = rdata;
        cmp_b   = bval_reg;
        cmp_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmp_a   = lower_top_reg;
                cmp_b   = src.sample;
                cmp_sel = HEAP_LOWER;
            end
            ST_PUSH_CMP:
            begin
                cmp_a = val_reg;
                cmp_b = rdata;
            end
            ST_POP_R:
            begin
                cmp_a = rdata;
                cmp_b = last_reg;
            end
            default:
            begin
                cmp_a = rdata;
                cmp_b = bval_reg;
            end
        endcase
    end

    assign hit       = above(cmp_a, cmp_b, cmp_sel);
    assign take_r    = r_in && hit;
    assign best_fin  = take_r ? r_idx : best_reg;
    assign bval_fin  = take_r ? rdata : bval_reg;
    assign sift_done = best_fin == {1'b0, idx_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    state_next = full ? ST_FINISH : ST_PUSH_UP;
                end
            ST_PUSH_UP:
                state_next = (idx_reg == '0) ? ST_BALANCE : ST_PUSH_CMP;
            ST_PUSH_CMP:
                state_next = hit ? ST_PUSH_UP : ST_BALANCE;
            ST_BALANCE:
                state_next = (!balanced_reg && (lower_big || upper_big)) ? ST_POP_LAST
                                                                         : ST_FINISH;
            ST_POP_LAST:
                state_next = ST_POP_L;
            ST_POP_L:
                state_next = l_out ? ST_POP_DONE : ST_POP_R;
            ST_POP_R:
                state_next = ST_POP_CMP;
            ST_POP_CMP:
                state_next = sift_done ? ST_POP_DONE : ST_POP_L;
            ST_POP_DONE:
                state_next = ST_PUSH_UP;
            ST_FINISH:
                state_next = res_hold ? ST_FINISH : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs: ram access, handshake, result
    always_comb
    begin
        req       = '0;
        res_valid = 1'b0;
        src.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                src.ready = 1'b1;
            ST_PUSH_UP:
                if (idx_reg == '0)
                begin
                    req.we    = 1'b1;
                    req.waddr = {sel_reg, idx_reg};
                    req.wdata = val_reg;
                end
                else
                begin
                    req.raddr = {sel_reg, parent};
                end
            ST_PUSH_CMP:
            begin
                req.we    = 1'b1;
                req.waddr = {sel_reg, idx_reg};
                req.wdata = hit ? rdata : val_reg;
            end
            ST_BALANCE:
            begin
                req.raddr = {pop_src, IDX_W'(src_size - SIZE_W'(1))};
            end
            ST_POP_L:
                if (l_out)
                begin
                    req.we    = 1'b1;
                    req.waddr = {sel_reg, idx_reg};
                    req.wdata = last_reg;
                end
                else
                begin
                    req.raddr = {sel_reg, l_idx[IDX_W-1:0]};
                end
            ST_POP_R:
            begin
                req.raddr = {sel_reg, r_idx[IDX_W-1:0]};
            end
            ST_POP_CMP:
            begin
                req.we    = 1'b1;
                req.waddr = {sel_reg, idx_reg};
                req.wdata = sift_done ? last_reg : bval_fin;
            end
            ST_FINISH:
                res_valid = !res_hold;
            default:
            begin
                req = '0;
            end
        endcase
    end

    always_comb
    begin
        res.dropped      = drop_reg;
        res.sample_count = total[CNT_W-1:0];
        if (lower_size_reg > upper_size_reg)
        begin
            res.median_doubled = {lower_top_reg, 1'b0};
        end
        else if (upper_size_reg > lower_size_reg)
        begin
            res.median_doubled = {upper_top_reg, 1'b0};
        end
        else if (lower_size_reg == '0)
        begin
            res.median_doubled = '0;
        end
        else
        begin
            res.median_doubled = {lower_top_reg[DATA_W-1], lower_top_reg}
                               + {upper_top_reg[DATA_W-1], upper_top_reg};
        end
    end

    assign stat.idle       = state_reg == ST_IDLE;
    assign stat.lower_size = lower_size_reg;
    assign stat.upper_size = upper_size_reg;

    // datapath
    always_comb
    begin
        sel_next        = sel_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        last_next       = last_reg;
        bval_next       = bval_reg;
        best_next       = best_reg;
        top_val_next    = top_val_reg;
        balanced_next   = balanced_reg;
        drop_next       = drop_reg;
        lower_size_next = lower_size_reg;
        upper_size_next = upper_size_reg;
        lower_top_next  = lower_top_reg;
        upper_top_next  = upper_top_reg;

        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    val_next      = src.sample;
                    drop_next     = full;
                    balanced_next = 1'b0;
                    if (!full)
                    begin
                        if (lower_size_reg == '0 || hit)
                        begin
                            sel_next        = HEAP_LOWER;
                            idx_next        = lower_size_reg[IDX_W-1:0];
                            lower_size_next = lower_size_reg + SIZE_W'(1);
                        end
                        else
                        begin
                            sel_next        = HEAP_UPPER;
                            idx_next        = upper_size_reg[IDX_W-1:0];
                            upper_size_next = upper_size_reg + SIZE_W'(1);
                        end
                    end
                end
            ST_PUSH_CMP:
                if (hit)
                begin
                    idx_next = parent;
                end
            ST_BALANCE:
                if (!balanced_reg && (lower_big || upper_big))
                begin
                    sel_next     = pop_src;
                    n_next       = src_size - SIZE_W'(1);
                    top_val_next = lower_big ? lower_top_reg : upper_top_reg;
                    if (lower_big)
                    begin
                        lower_size_next = src_size - SIZE_W'(1);
                    end
                    else
                    begin
                        upper_size_next = src_size - SIZE_W'(1);
                    end
                end
            ST_POP_LAST:
            begin
                last_next = rdata;
                idx_next  = '0;
            end
            ST_POP_R:
                if (hit)
                begin
                    best_next = l_idx;
                    bval_next = rdata;
                end
                else
                begin
                    best_next = {1'b0, idx_reg};
                    bval_next = last_reg;
                end
            ST_POP_CMP:
                if (!sift_done)
                begin
                    idx_next = best_fin[IDX_W-1:0];
                end
            ST_POP_DONE:
            begin
                val_next      = top_val_reg;
                balanced_next = 1'b1;
                if (sel_reg == HEAP_LOWER)
                begin
                    sel_next        = HEAP_UPPER;
                    idx_next        = upper_size_reg[IDX_W-1:0];
                    upper_size_next = upper_size_reg + SIZE_W'(1);
                end
                else
                begin
                    sel_next        = HEAP_LOWER;
                    idx_next        = lower_size_reg[IDX_W-1:0];
                    lower_size_next = lower_size_reg + SIZE_W'(1);
                end
            end
            default:
            begin
                drop_next = drop_reg;
            end
        endcase

        // mirror of each heap root
        if (req.we && req.waddr[IDX_W-1:0] == '0)
        begin
            if (req.waddr[ADDR_W-1] == HEAP_LOWER)
            begin
                lower_top_next = req.wdata;
            end
            else
            begin
                upper_top_next = req.wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lower_size_reg <= '0;
            upper_size_reg <= '0;
            balanced_reg   <= 1'b0;
            drop_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lower_size_reg <= lower_size_next;
            upper_size_reg <= upper_size_next;
            balanced_reg   <= balanced_next;
            drop_reg       <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg       <= sel_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        n_reg         <= n_next;
        last_reg      <= last_next;
        bval_reg      <= bval_next;
        best_reg      <= best_next;
        top_val_reg   <= top_val_next;
        lower_top_reg <= lower_top_next;
        upper_top_reg <= upper_top_next;
    end

endmodule
